// ----- hw/rtl/level_to_heatmap_rgb_macros.svh -----
// ----------------------------------------------------------------------------
// level_to_heatmap_rgb assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LEVEL_TO_HEATMAP_RGB_MACROS_SVH
`define LEVEL_TO_HEATMAP_RGB_MACROS_SVH

// check cons in the same cycle whenever ante holds
`define L2H_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("l2h assertion failed");

// check cond in every cycle
`define L2H_ASSERT_ALWAYS(label, cond) \
    `L2H_ASSERT_IMP(label, 1'b1, cond)

`endif

// ----- hw/rtl/l2h_pkg.sv -----
// ----------------------------------------------------------------------------
// l2h_pkg
// Types and constants of the level to heatmap colour mapper.
// ----------------------------------------------------------------------------
package l2h_pkg;

    localparam int LEVEL_W   = 16;
    localparam int CHAN_W    = 8;
    localparam int CFG_IDX_W = 1;

    typedef logic signed [LEVEL_W-1:0] t_level;
    typedef logic [CHAN_W-1:0]         t_chan;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_index;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_LEVEL  = 1'b0,
        CFG_HIGH_LEVEL = 1'b1
    } t_cfg_reg;

    localparam t_level LOW_LEVEL_RST  = 16'sd0;
    localparam t_level HIGH_LEVEL_RST = 16'sd12800;

endpackage

// ----- hw/rtl/level_to_heatmap_rgb.sv -----
// ----------------------------------------------------------------------------
// level_to_heatmap_rgb
// Maps a Q8.8 dB level to an 8-bit RGB heatmap colour through a normalised
// piecewise-linear colour ramp.
// ----------------------------------------------------------------------------
// Takes one level per clock: busy stays low, so a start is always a transfer.
// Each colour leaves in order through the input, divider, clamp, ramp-product
// and output stages, on o_valid for exactly one cycle; the receiver cannot
// stall. The normalising divider resolves one quotient bit per pipeline stage.
// Write the low and high levels only while no colour is outstanding;
// o_cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "level_to_heatmap_rgb_macros.svh"

module level_to_heatmap_rgb #(
    parameter int NORM_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  l2h_pkg::t_level       i_level,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  l2h_pkg::t_cfg_index   i_cfg_index,
    input  l2h_pkg::t_level       i_cfg_data,
    output logic                  o_valid,
    output l2h_pkg::t_chan        o_red,
    output l2h_pkg::t_chan        o_green,
    output l2h_pkg::t_chan        o_blue,
    output logic                  o_bad_range
);

    import l2h_pkg::*;

    localparam int NFB = NORM_FRAC_BITS;
    localparam int TW  = NFB + 1;
    localparam int PW  = NFB + 13;
    localparam int QW  = NFB + CHAN_W;
    localparam logic [TW-1:0] T_ONE = TW'(1) << NFB;
    localparam logic [PW-1:0] S     = PW'(1) << NFB;
    localparam logic [PW-1:0] K3    = PW'(3);
    localparam logic [PW-1:0] K5    = PW'(5);
    localparam logic [PW-1:0] K7    = PW'(7);
    localparam logic [PW-1:0] K9    = PW'(9);
    localparam logic [PW-1:0] K51   = PW'(51);
    localparam logic [PW-1:0] K85   = PW'(85);
    localparam logic [PW-1:0] K255  = PW'(255);

    // configuration
    t_level r_low;
    t_level r_high;

    // input stage
    logic                 w_accept;
    logic signed [16:0]   w_diff;
    logic signed [16:0]   w_span;
    logic                 r_a_vld;
    logic                 r_a_bad;
    logic                 r_a_lo;
    logic                 r_a_hi;
    logic [15:0]          r_a_diff;
    logic [15:0]          r_a_span;

    // divider stages
    logic [NFB-1:0]       r_d_vld;
    logic [NFB-1:0]       n_d_vld;
    logic [NFB-1:0]       r_d_bad;
    logic [NFB-1:0]       n_d_bad;
    logic [NFB-1:0]       r_d_lo;
    logic [NFB-1:0]       n_d_lo;
    logic [NFB-1:0]       r_d_hi;
    logic [NFB-1:0]       n_d_hi;
    logic [15:0]          r_d_rem  [NFB];
    logic [15:0]          n_d_rem  [NFB];
    logic [15:0]          r_d_span [NFB];
    logic [15:0]          n_d_span [NFB];
    logic [NFB-1:0]       r_d_quo  [NFB];
    logic [NFB-1:0]       n_d_quo  [NFB];
    logic                 w_div_live;

    // clamp stage
    logic                 r_t_vld;
    logic                 r_t_bad;
    logic [TW-1:0]        r_t;
    logic [TW-1:0]        n_t;

    // product stage
    logic                 r_p_vld;
    logic                 r_p_bad;
    logic [QW-1:0]        r_pr;
    logic [QW-1:0]        r_pg;
    logic [QW-1:0]        r_pb;
    logic [PW-1:0]        n_pr;
    logic [PW-1:0]        n_pg;
    logic [PW-1:0]        n_pb;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= LOW_LEVEL_RST;
            r_high <= HIGH_LEVEL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_LOW_LEVEL:  r_low  <= i_cfg_data;
                CFG_HIGH_LEVEL: r_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // offset and span of the level against the window
    assign w_diff = {i_level[15], i_level} - {r_low[15], r_low};
    assign w_span = {r_high[15], r_high} - {r_low[15], r_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_bad  <= w_span[16] || (w_span == 17'sd0);
        r_a_lo   <= w_diff[16] || (w_diff == 17'sd0);
        r_a_hi   <= (w_diff >= w_span);
        r_a_diff <= w_diff[15:0];
        r_a_span <= w_span[15:0];
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        logic [15:0]    rem_in;
        logic [NFB-1:0] quo_in;
        logic [16:0]    rem2;
        logic           ge;
        for (int k = 0; k < NFB; k++) begin
            if (k == 0) begin
                n_d_vld[k]  = r_a_vld;
                n_d_bad[k]  = r_a_bad;
                n_d_lo[k]   = r_a_lo;
                n_d_hi[k]   = r_a_hi;
                n_d_span[k] = r_a_span;
                rem_in      = r_a_diff;
                quo_in      = '0;
            end else begin
                n_d_vld[k]  = r_d_vld[k-1];
                n_d_bad[k]  = r_d_bad[k-1];
                n_d_lo[k]   = r_d_lo[k-1];
                n_d_hi[k]   = r_d_hi[k-1];
                n_d_span[k] = r_d_span[k-1];
                rem_in      = r_d_rem[k-1];
                quo_in      = r_d_quo[k-1];
            end
            rem2 = {rem_in, 1'b0};
            ge   = (rem2 >= {1'b0, n_d_span[k]});
            if (ge) begin
                n_d_rem[k] = 16'(rem2 - {1'b0, n_d_span[k]});
            end else begin
                n_d_rem[k] = rem2[15:0];
            end
            n_d_quo[k] = {quo_in[NFB-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= '0;
        end else begin
            r_d_vld <= n_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_bad  <= n_d_bad;
        r_d_lo   <= n_d_lo;
        r_d_hi   <= n_d_hi;
        r_d_rem  <= n_d_rem;
        r_d_span <= n_d_span;
        r_d_quo  <= n_d_quo;
    end

    // clamp t to [0,1]
    always_comb begin
        if (r_d_bad[NFB-1] || r_d_lo[NFB-1]) begin
            n_t = '0;
        end else if (r_d_hi[NFB-1]) begin
            n_t = T_ONE;
        end else begin
            n_t = {1'b0, r_d_quo[NFB-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else begin
            r_t_vld <= r_d_vld[NFB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_t_bad <= r_d_bad[NFB-1];
        r_t     <= n_t;
    end

    // ramp numerators, all scaled to a final shift by NFB
    always_comb begin
        logic [PW-1:0] t5;
        logic [PW-1:0] t10;
        logic [PW-1:0] t2;
        t5  = PW'(r_t) * K5;
        t10 = t5 << 1;
        t2  = PW'(r_t) << 1;

        n_pb = '0;
        if (t5 <= S) begin
            n_pb = K255 * t5;
        end else if (t10 <= K7 * S) begin
            n_pb = K51 * (K7 * S - t10);
        end

        n_pg = '0;
        if (t5 >= S && t5 <= K3 * S) begin
            n_pg = (K255 * (t5 - S)) >> 1;
        end else if (t5 > K3 * S && t10 <= K9 * S) begin
            n_pg = K85 * (K9 * S - t10);
        end

        n_pr = '0;
        if (t2 >= S) begin
            n_pr = K255 * (t2 - S);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= r_t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_bad <= r_t_bad;
        r_pr    <= n_pr[QW-1:0];
        r_pg    <= n_pg[QW-1:0];
        r_pb    <= n_pb[QW-1:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_bad_range <= r_p_bad;
        o_red       <= r_pr[QW-1:NFB];
        o_green     <= r_pg[QW-1:NFB];
        o_blue      <= r_pb[QW-1:NFB];
    end

    assign w_div_live = r_d_vld[NFB-1] && !r_d_bad[NFB-1] && !r_d_lo[NFB-1] && !r_d_hi[NFB-1];

    `L2H_ASSERT_IMP(a_t_in_range, r_t_vld, r_t <= T_ONE)
    `L2H_ASSERT_IMP(a_rem_below_span, w_div_live, r_d_rem[NFB-1] < r_d_span[NFB-1])
    `L2H_ASSERT_IMP(a_bad_is_black, o_valid && o_bad_range, {o_red, o_green, o_blue} == '0)
    `L2H_ASSERT_ALWAYS(a_never_busy, !busy && o_cfg_ready)

endmodule

// ----- dv/tb_level_to_heatmap_rgb.sv -----
// ----------------------------------------------------------------------------
// tb_level_to_heatmap_rgb
// Drives Q8.8 dB levels through the heatmap colour mapper under a series of
// low/high level settings (defaults, full span, reversed and empty ranges,
// narrow and random spans). Every transfer is mapped to its expected colour
// by an exact integer model of the normalise-and-ramp arithmetic and queued;
// each colour leaving the block is compared field by field with the oldest.
// ----------------------------------------------------------------------------
module tb_level_to_heatmap_rgb;

    import l2h_pkg::*;

    localparam int NORM_FRAC_BITS = 16;
    localparam int LATENCY        = NORM_FRAC_BITS + 4;
    localparam int IDLE_LIMIT     = 2000;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_LEVELS   = 60;

    typedef struct packed {
        t_level level;
        t_chan  red;
        t_chan  green;
        t_chan  blue;
        logic   bad_range;
    } t_colour;

    class heatmap_scoreboard;
        t_level  low_lvl;
        t_level  high_lvl;
        t_colour colour_due_q[$];
        int      errors;

        function new();
            low_lvl  = LOW_LEVEL_RST;
            high_lvl = HIGH_LEVEL_RST;
            errors   = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, t_level v);
            if (idx == CFG_LOW_LEVEL) begin
                low_lvl = v;
            end else begin
                high_lvl = v;
            end
        endfunction

        function t_colour map_level(t_level lv);
            t_colour c;
            longint  s, t, span, diff, r, g, b;
            c       = '0;
            c.level = lv;
            r = 0;
            g = 0;
            b = 0;
            if (high_lvl <= low_lvl) begin
                c.bad_range = 1'b1;
                return c;
            end
            s    = longint'(1) << NORM_FRAC_BITS;
            span = longint'(high_lvl) - longint'(low_lvl);
            diff = longint'(lv) - longint'(low_lvl);
            if (diff <= 0) begin
                t = 0;
            end else if (diff >= span) begin
                t = s;
            end else begin
                t = (diff * s) / span;
            end
            if (5 * t <= s) begin
                b = (255 * 5 * t) / s;
            end else if (10 * t <= 7 * s) begin
                b = (255 * (7 * s - 10 * t)) / (5 * s);
            end
            if (5 * t >= s && 5 * t <= 3 * s) begin
                g = (255 * (5 * t - s)) / (2 * s);
            end else if (5 * t > 3 * s && 10 * t <= 9 * s) begin
                g = (255 * (9 * s - 10 * t)) / (3 * s);
            end
            if (2 * t >= s) begin
                r = (255 * (2 * t - s)) / s;
            end
            c.red   = t_chan'(r);
            c.green = t_chan'(g);
            c.blue  = t_chan'(b);
            return c;
        endfunction

        function void note_level(t_level lv);
            colour_due_q.push_back(map_level(lv));
        endfunction

        function int pending();
            return colour_due_q.size();
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH: %s", what);
            errors++;
        endtask

        task check_colour(t_chan r, t_chan g, t_chan b, logic bad);
            t_colour want;
            if (colour_due_q.size() == 0) begin
                report_mismatch($sformatf("colour %0d/%0d/%0d/%0d with no level outstanding",
                                          r, g, b, bad));
                return;
            end
            want = colour_due_q.pop_front();
            if (r !== want.red) begin
                report_mismatch($sformatf("level %0d red %0d, want %0d",
                                          want.level, r, want.red));
            end
            if (g !== want.green) begin
                report_mismatch($sformatf("level %0d green %0d, want %0d",
                                          want.level, g, want.green));
            end
            if (b !== want.blue) begin
                report_mismatch($sformatf("level %0d blue %0d, want %0d",
                                          want.level, b, want.blue));
            end
            if (bad !== want.bad_range) begin
                report_mismatch($sformatf("level %0d bad_range %0d, want %0d",
                                          want.level, bad, want.bad_range));
            end
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_level     i_level;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_cfg_index i_cfg_index;
    t_level     i_cfg_data;
    logic       o_valid;
    t_chan      o_red;
    t_chan      o_green;
    t_chan      o_blue;
    logic       o_bad_range;

    heatmap_scoreboard sb = new();
    int idle_cycles = 0;
    int levels_sent = 0;

    level_to_heatmap_rgb #(
        .NORM_FRAC_BITS(NORM_FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_level     (i_level),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_bad_range (o_bad_range)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_level(i_level);
            end
            if (o_valid) begin
                sb.check_colour(o_red, o_green, o_blue, o_bad_range);
            end
            if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic int sender_idle_pct();
        if (levels_sent < 207) begin
            return 36;
        end else if (levels_sent < 414) begin
            return 49;
        end
        return 0;
    endfunction

    function automatic t_level clamp_level(int v);
        if (v < -32768) begin
            return t_level'(-32768);
        end else if (v > 32767) begin
            return t_level'(32767);
        end
        return t_level'(v);
    endfunction

    function automatic t_level pick_level(t_level lo, t_level hi);
        int span;
        int k;
        int v;
        span = int'(hi) - int'(lo);
        if (span <= 0) begin
            span = 256;
        end
        case ($urandom_range(9))
            0, 1: return t_level'($urandom);
            2: begin
                case ($urandom_range(5))
                    0: v = int'(lo);
                    1: v = int'(hi);
                    2: v = int'(lo) - 1;
                    3: v = int'(lo) + 1;
                    4: v = int'(hi) - 1;
                    default: v = int'(hi) + 1;
                endcase
            end
            3: begin
                case ($urandom_range(4))
                    0: k = 2;
                    1: k = 5;
                    2: k = 6;
                    3: k = 7;
                    default: k = 9;
                endcase
                v = int'(lo) + (span * k) / 10 + int'($urandom_range(4)) - 2;
            end
            default: v = int'(lo) - span / 8 + int'($urandom_range(span + span / 4));
        endcase
        return clamp_level(v);
    endfunction

    task automatic send_level(t_level lv);
        int pct;
        pct = sender_idle_pct();
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < pct) begin
                @(posedge i_clk);
            end
        end
        start   <= 1'b1;
        i_level <= lv;
        do @(posedge i_clk); while (busy);
        levels_sent++;
    endtask

    task automatic drain_colours();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // hold valid high between back-to-back writes; the caller drops it
    task automatic write_reg(t_cfg_reg idx, t_level v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, v);
    endtask

    task automatic pick_config(int ph, output t_level lo, output t_level hi);
        int span;
        int base;
        case (ph)
            1: begin
                lo = t_level'(-32768);
                hi = t_level'(32767);
            end
            2: begin
                lo = t_level'(32767);
                hi = t_level'(-32768);
            end
            3: begin
                lo = t_level'($urandom);
                hi = lo;
            end
            4: begin
                base = int'($urandom_range(65534)) - 32768;
                lo   = t_level'(base);
                hi   = t_level'(base + 1);
            end
            RAND_PHASES: begin
                lo = LOW_LEVEL_RST;
                hi = HIGH_LEVEL_RST;
            end
            default: begin
                if ($urandom_range(5) == 0) begin
                    lo = t_level'($urandom);
                    hi = t_level'($urandom);
                end else begin
                    span = int'($urandom_range(65535 >> $urandom_range(15), 1));
                    base = int'($urandom_range(65535 - span)) - 32768;
                    lo   = t_level'(base);
                    hi   = t_level'(base + span);
                end
            end
        endcase
    endtask

    initial begin
        t_level directed_levels[$];
        t_level lo;
        t_level hi;
        directed_levels = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1,
                            16'sd12800, 16'sd12799, 16'sd12801, 16'sd2560,
                            16'sd2559, 16'sd2561, 16'sd6400, 16'sd6399,
                            16'sd7680, 16'sd7681, 16'sd8960, 16'sd8961,
                            16'sd11520, 16'sd11521, 16'sd1280, 16'sd21845,
                            -16'sd21846};
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_level     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_levels[i]) begin
            send_level(directed_levels[i]);
        end

        for (int ph = 1; ph <= RAND_PHASES; ph++) begin
            drain_colours();
            pick_config(ph, lo, hi);
            if ($urandom_range(1)) begin
                write_reg(CFG_LOW_LEVEL, lo);
                write_reg(CFG_HIGH_LEVEL, hi);
            end else begin
                write_reg(CFG_HIGH_LEVEL, hi);
                write_reg(CFG_LOW_LEVEL, lo);
            end
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < PHASE_LEVELS; n++) begin
                send_level(pick_level(lo, hi));
            end
        end

        drain_colours();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("TIMEOUT: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
